>>> rtl/bfwm_pkg.sv
// Shared sizes, codes and request types of the bounded FIFO window mean unit.
package bfwm_pkg;

  localparam int WINDOW_DEPTH = 5;

  localparam int TAG_W  = 11;
  localparam int YEAR_W = 12;
  localparam int STAT_W = 2;
  localparam int FILL_W = 3;

  localparam int PTR_W   = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int COUNT_W = $clog2(WINDOW_DEPTH + 1);
  localparam int IDX_W   = COUNT_W + 1;
  localparam int SUM_W   = YEAR_W + COUNT_W;
  localparam int STEP_W  = $clog2(SUM_W + 1);

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 40;

  localparam logic [STAT_W-1:0] ST_INSERTED = 2'd0;
  localparam logic [STAT_W-1:0] ST_REMOVED  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd2;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_REMOVE = 1'b1;

  typedef struct packed {
    logic               we;
    logic [PTR_W-1:0]   addr;
    logic [TAG_W-1:0]   tag;
    logic [YEAR_W-1:0]  year;
  } store_wr_t;

  typedef struct packed {
    logic               start;
    logic [SUM_W-1:0]   dividend;
    logic [COUNT_W-1:0] divisor;
  } div_req_t;

endpackage

>>> rtl/bfwm_store.sv
// Slot memory holding the tag and year of each FIFO entry.
module bfwm_store
  import bfwm_pkg::*;
(
  input  logic              clk,
  input  store_wr_t         wr,
  input  logic [PTR_W-1:0]  rd_addr,
  output logic [TAG_W-1:0]  rd_tag,
  output logic [YEAR_W-1:0] rd_year
);

  logic [TAG_W-1:0]  tag_mem  [WINDOW_DEPTH];
  logic [YEAR_W-1:0] year_mem [WINDOW_DEPTH];

  always_ff @(posedge clk) begin
    if (wr.we) begin
      tag_mem[wr.addr]  <= wr.tag;
      year_mem[wr.addr] <= wr.year;
    end
  end

  always_ff @(posedge clk) begin
    rd_tag  <= tag_mem[rd_addr];
    rd_year <= year_mem[rd_addr];
  end

endmodule

>>> rtl/bfwm_divider.sv
// Restoring divider that takes one quotient bit per cycle.
module bfwm_divider
  import bfwm_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  div_req_t         req,
  output logic             done,
  output logic [SUM_W-1:0] quotient
);

  logic               busy_r;
  logic               done_r;
  logic [STEP_W-1:0]  step_r;
  logic [SUM_W-1:0]   quo_r;
  logic [COUNT_W-1:0] rem_r;
  logic [COUNT_W-1:0] dvs_r;

  logic [COUNT_W:0]   rem_shift;
  logic [COUNT_W:0]   rem_diff;
  logic               fits;
  logic [COUNT_W-1:0] rem_nxt;

  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SUM_W - 1);

  assign rem_shift = {rem_r, quo_r[SUM_W-1]};
  assign fits      = rem_shift >= {1'b0, dvs_r};
  assign rem_diff  = rem_shift - {1'b0, dvs_r};
  assign rem_nxt   = fits ? rem_diff[COUNT_W-1:0] : rem_shift[COUNT_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == LAST_STEP) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo_r <= req.dividend;
      rem_r <= '0;
      dvs_r <= req.divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[SUM_W-2:0], fits};
      rem_r <= rem_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

>>> rtl/bounded_fifo_window_mean_unit.sv
// Top level of the bounded FIFO window mean unit: sequencer, entry state and output register.
//
//   channel  direction  tdata                                 tuser
//   in_      slave      item_tag, year_value                  action
//   out_     master     mean_year, popped_tag, popped_year,   status
//                       fill_count
//
// A request is taken only while the sequencer is idle. An insert first pops the oldest entry when
// the store is full, then writes the slot and waits for the SUM_W steps of the bit-serial divider.
// A remove reads the slot and then loads the output; a refused remove loads the output directly.
// Reset clears the pointer, count, sum and handshake state; slots are not cleared.
// A stalled result waits in the output register; the sequencer holds until it is free.
module bounded_fifo_window_mean_unit
  import bfwm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // item_tag[10:0], year_value[22:11], zero pad
  input  logic [0:0]            in_tuser,   // action[0]
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // mean_year, popped_tag, popped_year, fill_count, pad
  output logic [STAT_W-1:0]     out_tuser   // status[1:0]
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_POP  = 3'd1;
  localparam logic [2:0] S_WR   = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  localparam logic [COUNT_W-1:0] CNT_FULL = COUNT_W'(WINDOW_DEPTH);
  localparam logic [IDX_W-1:0]   IDX_TOP  = IDX_W'(WINDOW_DEPTH);

  logic [2:0]         state_r, state_nxt;
  logic [PTR_W-1:0]   ptr_r, ptr_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;
  logic [SUM_W-1:0]   sum_r, sum_nxt;
  logic               act_r, act_nxt;
  logic [TAG_W-1:0]   tag_r, tag_nxt;
  logic [YEAR_W-1:0]  year_r, year_nxt;
  logic [STAT_W-1:0]  res_status_r, res_status_nxt;
  logic [YEAR_W-1:0]  res_mean_r, res_mean_nxt;
  logic [TAG_W-1:0]   res_ptag_r, res_ptag_nxt;
  logic [YEAR_W-1:0]  res_pyear_r, res_pyear_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic [STAT_W-1:0]  out_stat_r, out_stat_nxt;

  logic [TAG_W-1:0]   rd_tag;
  logic [YEAR_W-1:0]  rd_year;
  store_wr_t          wr;
  div_req_t           div_req;
  logic               div_done;
  logic [SUM_W-1:0]   div_quo;

  logic               in_acc;
  logic [IDX_W-1:0]   ptr_inc, wr_idx;
  logic [PTR_W-1:0]   ptr_wrap, wr_slot;
  logic [COUNT_W+FILL_W-1:0] fill_ext;

  assign in_acc = in_tvalid && in_tready;

  assign ptr_inc  = {{(IDX_W-PTR_W){1'b0}}, ptr_r} + 1'b1;
  assign ptr_wrap = (ptr_inc == IDX_TOP) ? '0 : ptr_inc[PTR_W-1:0];
  assign wr_idx   = {{(IDX_W-PTR_W){1'b0}}, ptr_r} + {1'b0, count_r};
  assign wr_slot  = (wr_idx >= IDX_TOP) ? PTR_W'(wr_idx - IDX_TOP) : wr_idx[PTR_W-1:0];
  assign fill_ext = {{FILL_W{1'b0}}, count_r};

  bfwm_store u_store (
    .clk     (clk),
    .wr      (wr),
    .rd_addr (ptr_r),
    .rd_tag  (rd_tag),
    .rd_year (rd_year)
  );

  bfwm_divider u_divider (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_comb begin
    state_nxt      = state_r;
    ptr_nxt        = ptr_r;
    count_nxt      = count_r;
    sum_nxt        = sum_r;
    act_nxt        = act_r;
    tag_nxt        = tag_r;
    year_nxt       = year_r;
    res_status_nxt = res_status_r;
    res_mean_nxt   = res_mean_r;
    res_ptag_nxt   = res_ptag_r;
    res_pyear_nxt  = res_pyear_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    out_stat_nxt   = out_stat_r;
    wr             = '0;
    div_req        = '0;
    in_tready      = (state_r == S_IDLE);

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          act_nxt  = in_tuser[0];
          tag_nxt  = in_tdata[TAG_W-1:0];
          year_nxt = in_tdata[TAG_W+YEAR_W-1:TAG_W];
          res_mean_nxt  = '0;
          res_ptag_nxt  = '0;
          res_pyear_nxt = '0;
          if (in_tuser[0] == ACT_INSERT) begin
            state_nxt = (count_r >= CNT_FULL) ? S_POP : S_WR;
          end else if (count_r == '0) begin
            res_status_nxt = ST_EMPTY;
            state_nxt      = S_OUT;
          end else begin
            state_nxt = S_POP;
          end
        end
      end
      S_POP: begin
        sum_nxt   = sum_r - {{(SUM_W-YEAR_W){1'b0}}, rd_year};
        ptr_nxt   = ptr_wrap;
        count_nxt = count_r - 1'b1;
        if (act_r == ACT_REMOVE) begin
          res_status_nxt = ST_REMOVED;
          res_ptag_nxt   = rd_tag;
          res_pyear_nxt  = rd_year;
          state_nxt      = S_OUT;
        end else begin
          state_nxt = S_WR;
        end
      end
      S_WR: begin
        wr.we            = 1'b1;
        wr.addr          = wr_slot;
        wr.tag           = tag_r;
        wr.year          = year_r;
        count_nxt        = count_r + 1'b1;
        sum_nxt          = sum_r + {{(SUM_W-YEAR_W){1'b0}}, year_r};
        div_req.start    = 1'b1;
        div_req.dividend = sum_nxt;
        div_req.divisor  = count_nxt;
        res_status_nxt   = ST_INSERTED;
        state_nxt        = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          res_mean_nxt = div_quo[YEAR_W-1:0];
          state_nxt    = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_stat_nxt  = res_status_r;
          out_data_nxt  = {{(OUT_DATA_W-2*YEAR_W-TAG_W-FILL_W){1'b0}},
                           fill_ext[FILL_W-1:0], res_pyear_r, res_ptag_r, res_mean_r};
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ptr_r       <= '0;
      count_r     <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ptr_r       <= ptr_nxt;
      count_r     <= count_nxt;
      sum_r       <= sum_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r        <= act_nxt;
    tag_r        <= tag_nxt;
    year_r       <= year_nxt;
    res_status_r <= res_status_nxt;
    res_mean_r   <= res_mean_nxt;
    res_ptag_r   <= res_ptag_nxt;
    res_pyear_r  <= res_pyear_nxt;
    out_data_r   <= out_data_nxt;
    out_stat_r   <= out_stat_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_stat_r;

endmodule

>>> rtl/bfwm_checker.sv
// Port-level assertions for the bounded FIFO window mean unit, bound to its top level.
module bfwm_checker
  import bfwm_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic [STAT_W-1:0]     out_tuser
);

  localparam int PTAG_LO  = YEAR_W;
  localparam int PYEAR_LO = YEAR_W + TAG_W;
  localparam int FILL_LO  = 2 * YEAR_W + TAG_W;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request taken while previous one is still in work");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ST_EMPTY |-> out_tdata == '0)
    else $error("refused remove carries nonzero fields");

  a_no_pop_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != ST_REMOVED |->
      out_tdata[PYEAR_LO+YEAR_W-1:PTAG_LO] == '0)
    else $error("popped fields set without a remove");

  a_insert_fill: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ST_INSERTED |->
      out_tdata[FILL_LO+FILL_W-1:FILL_LO] != '0)
    else $error("insert reports an empty store");

endmodule

bind bounded_fifo_window_mean_unit bfwm_checker u_bfwm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
